// File: rtl/slpg_pkg.sv
// Package for the status LED pattern generator.
// Holds the mode type, register indexes, colour constants and reset values.
// No dependencies.
package slpg_pkg;

    typedef enum logic [1:0] {
        LINK_IDLE = 2'd0,
        LINK_STA  = 2'd1,
        LINK_AP   = 2'd2,
        LINK_DOWN = 2'd3
    } mode_t;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int PERIOD_W    = 16;
    localparam int LEVEL_W     = 8;
    localparam int COLOUR_W    = 24;

    typedef logic [CFG_INDEX_W-1:0] cfg_index_t;
    typedef logic [PERIOD_W-1:0]    period_t;
    typedef logic [LEVEL_W-1:0]     level_t;
    typedef logic [COLOUR_W-1:0]    colour_t;

    localparam cfg_index_t REG_PULSE_PERIOD = 3'd0;
    localparam cfg_index_t REG_SCAN_PERIOD  = 3'd1;
    localparam cfg_index_t REG_AP_PERIOD    = 3'd2;
    localparam cfg_index_t REG_PULSE_TOP    = 3'd3;
    localparam cfg_index_t REG_PULSE_BOTTOM = 3'd4;
    localparam cfg_index_t REG_PULSE_INC    = 3'd5;

    localparam period_t RST_PULSE_PERIOD = 16'd20;
    localparam period_t RST_SCAN_PERIOD  = 16'd200;
    localparam period_t RST_AP_PERIOD    = 16'd300;
    localparam level_t  RST_PULSE_TOP    = 8'd100;
    localparam level_t  RST_PULSE_BOTTOM = 8'd10;
    localparam level_t  RST_PULSE_INC    = 8'd2;

    localparam period_t TICKS_FULL = {PERIOD_W{1'b1}};
    localparam level_t  LEVEL_MAX  = {LEVEL_W{1'b1}};

    localparam colour_t COLOUR_GREEN    = 24'h00FF00;
    localparam colour_t COLOUR_RED      = 24'hFF0000;
    localparam colour_t COLOUR_CYAN     = 24'h00FFFF;
    localparam colour_t COLOUR_CYAN_DIM = 24'h003232;
    localparam colour_t COLOUR_ORANGE   = 24'hFFA500;
    localparam colour_t COLOUR_ORNG_DIM = 24'h321900;

endpackage

// File: rtl/slpg_tick_if.sv
// Tick channel: valid/ready handshake carrying link mode and scan flag.
// Depends on slpg_pkg.
interface slpg_tick_if;
    import slpg_pkg::*;

    logic  valid;
    logic  ready;
    mode_t mode;
    logic  scanning;

    modport source (output valid, output mode, output scanning, input ready);
    modport sink   (input valid, input mode, input scanning, output ready);
endinterface

// File: rtl/slpg_led_if.sv
// LED channel: valid/ready handshake carrying write strobe and RGB colour.
// Depends on slpg_pkg.
interface slpg_led_if;
    import slpg_pkg::*;

    logic   valid;
    logic   ready;
    logic   write;
    level_t red;
    level_t green;
    level_t blue;

    modport source (output valid, output write, output red, output green, output blue,
                    input ready);
    modport sink   (input valid, input write, input red, input green, input blue,
                    output ready);
endinterface

// File: rtl/status_led_pattern_generator.sv
// Status LED pattern generator top level: input register, pattern update, result register.
// Depends on slpg_pkg, slpg_tick_if and slpg_led_if.
//
//  channel  | dir | payload                   | transfer when
//  ---------+-----+---------------------------+--------------------------
//  tick     | in  | mode, scanning            | tick.valid && tick.ready
//  led      | out | write, red, green, blue   | led.valid && led.ready
//  cfg      | in  | cfg_index, cfg_data       | cfg_wr_en
//
// One tick per clock sustained while led.ready holds; led.valid comes from the output register.
// The input register feeds the update logic, whose result lands in the output register.
// A stalled output holds its result while one further tick waits in the input register.
// Reset restores register defaults, saturated timers and a black colour.
module status_led_pattern_generator (
    input  logic                                clk,
    input  logic                                rst_n,
    slpg_tick_if.sink                           tick,
    slpg_led_if.source                          led,
    input  logic                                cfg_wr_en,
    input  logic [slpg_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [slpg_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import slpg_pkg::*;

    period_t pulse_period_reg;
    period_t scan_period_reg;
    period_t ap_period_reg;
    level_t  pulse_top_reg;
    level_t  pulse_bottom_reg;
    level_t  pulse_inc_reg;

    logic    s1_valid_reg;
    mode_t   s1_mode_reg;
    logic    s1_scanning_reg;

    period_t tsp_reg, tsp_next;
    period_t tsb_reg, tsb_next;
    logic    phase_reg, phase_next;
    logic    fading_reg, fading_next;
    level_t  level_reg, level_next;

    logic    out_valid_reg, out_valid_next;
    logic    out_write_reg, out_write_next;
    colour_t colour_reg, colour_next;

    logic    advance;
    period_t tsp_inc, tsb_inc, blink_period;
    logic    pulse_fire, blink_fire;
    logic [LEVEL_W:0] level_sum;
    level_t  level_up, level_dn;

    assign advance   = s1_valid_reg && (!out_valid_reg || led.ready);
    assign tick.ready = !s1_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pulse_period_reg <= RST_PULSE_PERIOD;
            scan_period_reg  <= RST_SCAN_PERIOD;
            ap_period_reg    <= RST_AP_PERIOD;
            pulse_top_reg    <= RST_PULSE_TOP;
            pulse_bottom_reg <= RST_PULSE_BOTTOM;
            pulse_inc_reg    <= RST_PULSE_INC;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_PULSE_PERIOD: pulse_period_reg <= cfg_data;
                REG_SCAN_PERIOD:  scan_period_reg  <= cfg_data;
                REG_AP_PERIOD:    ap_period_reg    <= cfg_data;
                REG_PULSE_TOP:    pulse_top_reg    <= cfg_data[LEVEL_W-1:0];
                REG_PULSE_BOTTOM: pulse_bottom_reg <= cfg_data[LEVEL_W-1:0];
                REG_PULSE_INC:    pulse_inc_reg    <= cfg_data[LEVEL_W-1:0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (tick.ready)
            s1_valid_reg <= tick.valid;
    end

    always_ff @(posedge clk)
    begin
        if (tick.valid && tick.ready)
        begin
            s1_mode_reg     <= tick.mode;
            s1_scanning_reg <= tick.scanning;
        end
    end

    assign tsp_inc      = (tsp_reg == TICKS_FULL) ? tsp_reg : tsp_reg + 1'b1;
    assign tsb_inc      = (tsb_reg == TICKS_FULL) ? tsb_reg : tsb_reg + 1'b1;
    assign blink_period = (s1_mode_reg == LINK_AP) ? ap_period_reg : scan_period_reg;
    assign pulse_fire   = tsp_inc >= pulse_period_reg;
    assign blink_fire   = tsb_inc >= blink_period;

    assign level_sum = {1'b0, level_reg} + {1'b0, pulse_inc_reg};
    assign level_up  = level_sum[LEVEL_W] ? LEVEL_MAX : level_sum[LEVEL_W-1:0];
    assign level_dn  = (level_reg >= pulse_inc_reg) ? level_reg - pulse_inc_reg : '0;

    always_comb
    begin
        tsp_next       = tsp_reg;
        tsb_next       = tsb_reg;
        phase_next     = phase_reg;
        fading_next    = fading_reg;
        level_next     = level_reg;
        colour_next    = colour_reg;
        out_write_next = out_write_reg;
        out_valid_next = led.ready ? 1'b0 : out_valid_reg;

        if (advance)
        begin
            out_valid_next = 1'b1;
            out_write_next = 1'b0;
            tsp_next       = tsp_inc;
            tsb_next       = tsb_inc;
            unique case (s1_mode_reg)
                LINK_IDLE:
                begin
                    if (pulse_fire)
                    begin
                        tsp_next = '0;
                        if (!fading_reg)
                        begin
                            level_next = level_up;
                            if (level_up >= pulse_top_reg)
                                fading_next = 1'b1;
                        end
                        else
                        begin
                            level_next = level_dn;
                            if (level_dn <= pulse_bottom_reg)
                                fading_next = 1'b0;
                        end
                        colour_next    = {{(COLOUR_W-LEVEL_W){1'b0}}, level_next};
                        out_write_next = 1'b1;
                    end
                end
                LINK_STA:
                begin
                    if (!s1_scanning_reg)
                    begin
                        colour_next    = COLOUR_GREEN;
                        out_write_next = 1'b1;
                    end
                    else if (blink_fire)
                    begin
                        tsb_next       = '0;
                        phase_next     = !phase_reg;
                        colour_next    = !phase_reg ? COLOUR_CYAN : COLOUR_CYAN_DIM;
                        out_write_next = 1'b1;
                    end
                end
                LINK_AP:
                begin
                    if (blink_fire)
                    begin
                        tsb_next       = '0;
                        phase_next     = !phase_reg;
                        colour_next    = !phase_reg ? COLOUR_ORANGE : COLOUR_ORNG_DIM;
                        out_write_next = 1'b1;
                    end
                end
                LINK_DOWN:
                begin
                    colour_next    = COLOUR_RED;
                    out_write_next = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tsp_reg       <= TICKS_FULL;
            tsb_reg       <= TICKS_FULL;
            phase_reg     <= 1'b0;
            fading_reg    <= 1'b0;
            level_reg     <= '0;
            colour_reg    <= '0;
            out_valid_reg <= 1'b0;
            out_write_reg <= 1'b0;
        end
        else
        begin
            tsp_reg       <= tsp_next;
            tsb_reg       <= tsb_next;
            phase_reg     <= phase_next;
            fading_reg    <= fading_next;
            level_reg     <= level_next;
            colour_reg    <= colour_next;
            out_valid_reg <= out_valid_next;
            out_write_reg <= out_write_next;
        end
    end

    assign led.valid = out_valid_reg;
    assign led.write = out_write_reg;
    assign led.red   = colour_reg[23:16];
    assign led.green = colour_reg[15:8];
    assign led.blue  = colour_reg[7:0];

`ifndef NO_ASSERTIONS
    // a held tick stays in the input register until the output frees up
    a_hold_tick: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !advance |=> s1_valid_reg)
        else $error("pending tick dropped");

    // off mode always pushes red
    a_off_red: assert property (@(posedge clk) disable iff (!rst_n)
        advance && s1_mode_reg == LINK_DOWN |=>
        out_valid_reg && out_write_reg && colour_reg == COLOUR_RED)
        else $error("off mode did not push red");

    // a pulse step restarts its timer
    a_pulse_restart: assert property (@(posedge clk) disable iff (!rst_n)
        advance && s1_mode_reg == LINK_IDLE && pulse_fire |=> tsp_reg == '0)
        else $error("pulse timer not restarted");
`endif

endmodule

// File: tb/tb_top.sv
// Testbench for status_led_pattern_generator: a directed table, then random tick streams
// under varying register settings, each LED transfer checked against the table or an in-bench predictor.
// Depends on slpg_pkg, slpg_tick_if, slpg_led_if and the top-level RTL.
module tb_top;
    import slpg_pkg::*;

    localparam int N_DIR_ROWS      = 30;
    localparam int N_PHASES        = 6;
    localparam int ITEMS_PER_PHASE = 165;
    localparam int QUIET_LIMIT     = 4000;

    typedef enum logic { ROW_TICK, ROW_CFG } row_kind_t;

    typedef struct packed {
        logic   write;
        level_t red;
        level_t green;
        level_t blue;
    } led_item_t;

    typedef struct packed {
        period_t pulse_period;
        period_t scan_period;
        period_t ap_period;
        level_t  pulse_top;
        level_t  pulse_bottom;
        level_t  pulse_inc;
    } reg_set_t;

    typedef struct {
        row_kind_t kind;
        mode_t     m;
        logic      scan;
        logic      typed;
        led_item_t want;
        reg_set_t  regs;
    } step_row_t;

    logic       clk;
    logic       rst_n;
    logic       cfg_wr_en;
    cfg_index_t cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    slpg_tick_if tick_if ();
    slpg_led_if  led_if ();

    status_led_pattern_generator u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .tick      (tick_if),
        .led       (led_if),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // predictor state
    reg_set_t  cur_regs;
    period_t   ticks_pulse;
    period_t   ticks_blink;
    logic      blink_on;
    logic      fading;
    level_t    pulse_lvl;
    colour_t   shown;

    led_item_t expected_leds [$];
    int        mismatches = 0;
    int        send_idle_pct = 0;
    int        recv_idle_pct = 0;

    step_row_t dir_steps [N_DIR_ROWS] = '{
        '{ROW_TICK, LINK_IDLE, 1'b0, 1'b1, {1'b1, 24'h000002},     '0},
        '{ROW_TICK, LINK_IDLE, 1'b0, 1'b1, {1'b0, 24'h000002},     '0},
        '{ROW_TICK, LINK_DOWN, 1'b0, 1'b1, {1'b1, COLOUR_RED},     '0},
        '{ROW_TICK, LINK_STA,  1'b0, 1'b1, {1'b1, COLOUR_GREEN},   '0},
        '{ROW_TICK, LINK_STA,  1'b1, 1'b1, {1'b1, COLOUR_CYAN},    '0},
        '{ROW_TICK, LINK_AP,   1'b1, 1'b1, {1'b0, COLOUR_CYAN},    '0},
        '{ROW_TICK, LINK_STA,  1'b1, 1'b1, {1'b0, COLOUR_CYAN},    '0},
        // zero scan period fires every tick
        '{ROW_CFG,  LINK_IDLE, 1'b0, 1'b0, '0,
          {RST_PULSE_PERIOD, 16'd0, 16'd1, RST_PULSE_TOP, RST_PULSE_BOTTOM, RST_PULSE_INC}},
        '{ROW_TICK, LINK_STA,  1'b1, 1'b1, {1'b1, COLOUR_CYAN_DIM}, '0},
        '{ROW_TICK, LINK_STA,  1'b1, 1'b1, {1'b1, COLOUR_CYAN},     '0},
        '{ROW_TICK, LINK_AP,   1'b0, 1'b1, {1'b1, COLOUR_ORNG_DIM}, '0},
        '{ROW_TICK, LINK_AP,   1'b1, 1'b1, {1'b1, COLOUR_ORANGE},   '0},
        // level saturates at the top, then drops to zero
        '{ROW_CFG,  LINK_IDLE, 1'b0, 1'b0, '0,
          {16'd0, 16'd0, 16'd1, 8'd255, 8'd0, 8'd255}},
        '{ROW_TICK, LINK_IDLE, 1'b0, 1'b1, {1'b1, 24'h0000FF},     '0},
        '{ROW_TICK, LINK_IDLE, 1'b0, 1'b1, {1'b1, 24'h000000},     '0},
        // zero increment, turning tests still apply
        '{ROW_CFG,  LINK_IDLE, 1'b0, 1'b0, '0,
          {16'd0, 16'd0, 16'd1, 8'd0, 8'd0, 8'd0}},
        '{ROW_TICK, LINK_IDLE, 1'b0, 1'b0, '0, '0},
        '{ROW_TICK, LINK_IDLE, 1'b0, 1'b0, '0, '0},
        '{ROW_CFG,  LINK_IDLE, 1'b0, 1'b0, '0,
          {16'd1, 16'd65535, 16'd65535, 8'd3, 8'd2, 8'd1}},
        '{ROW_TICK, LINK_IDLE, 1'b0, 1'b0, '0, '0},
        '{ROW_TICK, LINK_IDLE, 1'b1, 1'b0, '0, '0},
        '{ROW_TICK, LINK_IDLE, 1'b0, 1'b0, '0, '0},
        '{ROW_TICK, LINK_IDLE, 1'b1, 1'b0, '0, '0},
        '{ROW_TICK, LINK_IDLE, 1'b0, 1'b0, '0, '0},
        '{ROW_CFG,  LINK_IDLE, 1'b0, 1'b0, '0,
          {16'd65535, 16'd65535, 16'd65535, 8'd255, 8'd255, 8'd128}},
        '{ROW_TICK, LINK_IDLE, 1'b0, 1'b0, '0, '0},
        '{ROW_TICK, LINK_AP,   1'b1, 1'b0, '0, '0},
        '{ROW_TICK, LINK_STA,  1'b1, 1'b0, '0, '0},
        '{ROW_TICK, LINK_DOWN, 1'b1, 1'b0, '0, '0},
        '{ROW_TICK, LINK_STA,  1'b0, 1'b0, '0, '0}
    };

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic logic blink_toggle(period_t period, colour_t bright, colour_t dim,
                                          inout colour_t c);
        if (ticks_blink < period)
            return 1'b0;
        ticks_blink = '0;
        blink_on    = ~blink_on;
        c           = blink_on ? bright : dim;
        return 1'b1;
    endfunction

    function automatic led_item_t predict_colour(mode_t m, logic scan);
        led_item_t  r;
        logic [8:0] sum;
        colour_t    c;
        c       = shown;
        r.write = 1'b0;
        if (ticks_pulse != TICKS_FULL)
            ticks_pulse++;
        if (ticks_blink != TICKS_FULL)
            ticks_blink++;
        case (m)
            LINK_IDLE:
            begin
                if (ticks_pulse >= cur_regs.pulse_period)
                begin
                    ticks_pulse = '0;
                    if (!fading)
                    begin
                        sum       = {1'b0, pulse_lvl} + {1'b0, cur_regs.pulse_inc};
                        pulse_lvl = sum[8] ? LEVEL_MAX : sum[7:0];
                        if (pulse_lvl >= cur_regs.pulse_top)
                            fading = 1'b1;
                    end
                    else
                    begin
                        pulse_lvl = (pulse_lvl >= cur_regs.pulse_inc) ?
                                    pulse_lvl - cur_regs.pulse_inc : '0;
                        if (pulse_lvl <= cur_regs.pulse_bottom)
                            fading = 1'b0;
                    end
                    c       = {16'h0000, pulse_lvl};
                    r.write = 1'b1;
                end
            end
            LINK_STA:
            begin
                if (scan)
                    r.write = blink_toggle(cur_regs.scan_period, COLOUR_CYAN, COLOUR_CYAN_DIM, c);
                else
                begin
                    c       = COLOUR_GREEN;
                    r.write = 1'b1;
                end
            end
            LINK_AP:
                r.write = blink_toggle(cur_regs.ap_period, COLOUR_ORANGE, COLOUR_ORNG_DIM, c);
            default:
            begin
                c       = COLOUR_RED;
                r.write = 1'b1;
            end
        endcase
        shown   = c;
        r.red   = c[23:16];
        r.green = c[15:8];
        r.blue  = c[7:0];
        return r;
    endfunction

    function automatic period_t rand_period();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return '0;
        if (r == 1)
            return TICKS_FULL;
        if (r == 2)
            return period_t'($urandom_range(1, 65535));
        return period_t'($urandom_range(1, 12));
    endfunction

    // valid stays up across back-to-back transfers
    task automatic send_tick(mode_t m, logic scan, logic typed, led_item_t want);
        led_item_t got;
        while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct)
        begin
            tick_if.valid <= 1'b0;
            @(posedge clk);
        end
        tick_if.valid    <= 1'b1;
        tick_if.mode     <= m;
        tick_if.scanning <= scan;
        @(posedge clk);
        while (!tick_if.ready)
            @(posedge clk);
        got = predict_colour(m, scan);
        expected_leds.push_back(typed ? want : got);
    endtask

    task automatic write_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    // drains the pipe first so registers only change while idle
    task automatic apply_regs(reg_set_t r);
        tick_if.valid <= 1'b0;
        while (expected_leds.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        write_reg(REG_PULSE_PERIOD, r.pulse_period);
        write_reg(REG_SCAN_PERIOD,  r.scan_period);
        write_reg(REG_AP_PERIOD,    r.ap_period);
        write_reg(REG_PULSE_TOP,    {8'h00, r.pulse_top});
        write_reg(REG_PULSE_BOTTOM, {8'h00, r.pulse_bottom});
        write_reg(REG_PULSE_INC,    {8'h00, r.pulse_inc});
        cfg_wr_en <= 1'b0;
        cur_regs = r;
    endtask

    initial
    begin
        led_if.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            led_if.ready <= (recv_idle_pct == 0) || ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin : scoreboard
        led_item_t want;
        if (rst_n && led_if.valid && led_if.ready)
        begin
            if (expected_leds.size() == 0)
            begin
                $error("LED transfer with nothing expected");
                mismatches++;
            end
            else
            begin
                want = expected_leds.pop_front();
                if (led_if.write !== want.write)
                begin
                    $error("write: expected %0d, actual %0d", want.write, led_if.write);
                    mismatches++;
                end
                if (led_if.red !== want.red)
                begin
                    $error("red: expected %0d, actual %0d", want.red, led_if.red);
                    mismatches++;
                end
                if (led_if.green !== want.green)
                begin
                    $error("green: expected %0d, actual %0d", want.green, led_if.green);
                    mismatches++;
                end
                if (led_if.blue !== want.blue)
                begin
                    $error("blue: expected %0d, actual %0d", want.blue, led_if.blue);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((tick_if.valid && tick_if.ready) || (led_if.valid && led_if.ready) || cfg_wr_en)
                quiet = 0;
            else
                quiet++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin : stimulus
        reg_set_t r;
        mode_t    run_mode;
        logic     run_scan;
        int       run_len;
        int       sent;

        rst_n            = 1'b0;
        tick_if.valid    = 1'b0;
        tick_if.mode     = LINK_IDLE;
        tick_if.scanning = 1'b0;
        cfg_wr_en        = 1'b0;
        cfg_index        = REG_PULSE_PERIOD;
        cfg_data         = '0;

        cur_regs    = {RST_PULSE_PERIOD, RST_SCAN_PERIOD, RST_AP_PERIOD,
                       RST_PULSE_TOP, RST_PULSE_BOTTOM, RST_PULSE_INC};
        ticks_pulse = TICKS_FULL;
        ticks_blink = TICKS_FULL;
        blink_on    = 1'b0;
        fading      = 1'b0;
        pulse_lvl   = '0;
        shown       = '0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < N_DIR_ROWS; i++)
        begin
            if (dir_steps[i].kind == ROW_CFG)
                apply_regs(dir_steps[i].regs);
            else
                send_tick(dir_steps[i].m, dir_steps[i].scan, dir_steps[i].typed,
                          dir_steps[i].want);
        end

        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            if (ph < 2)
            begin
                send_idle_pct = 22;
                recv_idle_pct = 73;
            end
            else if (ph < 4)
            begin
                send_idle_pct = 73;
                recv_idle_pct = 22;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end

            r.pulse_period = rand_period();
            r.scan_period  = rand_period();
            r.ap_period    = rand_period();
            r.pulse_top    = level_t'($urandom_range(0, 255));
            r.pulse_bottom = $urandom_range(0, 1) ? level_t'($urandom_range(0, r.pulse_top))
                                                  : level_t'($urandom_range(0, 255));
            case ($urandom_range(0, 9))
                0:       r.pulse_inc = '0;
                1:       r.pulse_inc = LEVEL_MAX;
                default: r.pulse_inc = level_t'($urandom_range(1, 30));
            endcase
            apply_regs(r);

            sent = 0;
            while (sent < ITEMS_PER_PHASE)
            begin
                run_mode = mode_t'($urandom_range(0, 3));
                run_scan = $urandom_range(0, 1);
                run_len  = $urandom_range(1, 40);
                for (int k = 0; k < run_len && sent < ITEMS_PER_PHASE; k++)
                begin
                    send_tick(run_mode, ($urandom_range(0, 9) == 0) ? ~run_scan : run_scan,
                              1'b0, '0);
                    sent++;
                end
            end
        end

        tick_if.valid <= 1'b0;
        while (expected_leds.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (mismatches == 0 && expected_leds.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
